@@ src/snfce_pkg.sv @@
// Shared types, constants and codes for the SPI NOR flash command engine.
package snfce_pkg;

  localparam int MEM_ADDR_BITS = 19;
  localparam int SECTOR_BYTES  = 4096;
  localparam int PAGE_BYTES    = 256;
  localparam int SECTOR_BITS   = $clog2(SECTOR_BYTES);
  localparam int PAGE_BITS     = $clog2(PAGE_BYTES);
  localparam int ADDR_BITS     = 24;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int MIN_DENSITY   = 13;
  localparam int PADDR_BITS    = 3;

  localparam logic [4:0]  DENSITY_RESET = 5'd19;
  localparam logic [15:0] MAKER_RESET   = 16'hC228;
  localparam logic [7:0]  INIT_OFFSET   = 8'h55;
  localparam logic [7:0]  ERASED_BYTE   = 8'hFF;

  localparam logic [PADDR_BITS-1:0] REG_DENSITY = 3'd0;
  localparam logic [PADDR_BITS-1:0] REG_MAKER   = 3'd4;

  localparam logic [1:0] OP_SELECT   = 2'd0;
  localparam logic [1:0] OP_DESELECT = 2'd1;
  localparam logic [1:0] OP_WRITE    = 2'd2;
  localparam logic [1:0] OP_READ     = 2'd3;

  localparam logic [7:0] CMD_PDOWN   = 8'hB9;
  localparam logic [7:0] CMD_RELEASE = 8'hAB;
  localparam logic [7:0] CMD_READ_ID = 8'h9F;
  localparam logic [7:0] CMD_WREN    = 8'h06;
  localparam logic [7:0] CMD_RDSR    = 8'h05;
  localparam logic [7:0] CMD_READ    = 8'h03;
  localparam logic [7:0] CMD_BULK    = 8'hC7;
  localparam logic [7:0] CMD_PROG    = 8'h02;
  localparam logic [7:0] CMD_SECTOR  = 8'h20;

  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_CMD   = 3'd1;
  localparam logic [2:0] ERR_PHASE = 3'd2;
  localparam logic [2:0] ERR_RANGE = 3'd3;
  localparam logic [2:0] ERR_PAGE  = 3'd4;
  localparam logic [2:0] ERR_ALIGN = 3'd5;

  localparam logic [1:0] JOB_RESULT  = 2'd0;
  localparam logic [1:0] JOB_READ    = 2'd1;
  localparam logic [1:0] JOB_PROGRAM = 2'd2;
  localparam logic [1:0] JOB_ERASE   = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_in;
  } in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic [2:0] error_code;
  } out_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [MEM_ADDR_BITS-1:0] addr;
    logic [MEM_ADDR_BITS:0]   last;
    logic [7:0]               data;
    logic [2:0]               err;
  } job_t;

endpackage

@@ src/spi_nor_flash_command_engine.sv @@
// Top level of the SPI NOR flash command engine with its APB register port.
//
//   channel   handshake                     payload
//   command   start_i, accepted if !busy_o  cmd_i (op, data_in)
//   result    done_o, one cycle             result_o (data_out, error_code)
//   config    APB psel/penable/pwrite       paddr, pwdata, prdata
//
// A sector erase sweeps its sector, a bulk erase the usable size of the array.
// After reset the array is filled with its initial pattern, with busy_o high.
// A two-entry queue lets commands be taken while an erase runs; results cannot be stalled.
module spi_nor_flash_command_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  snfce_pkg::in_t                      cmd_i,
  output logic                                done_o,
  output snfce_pkg::out_t                     result_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [snfce_pkg::PADDR_BITS-1:0]    paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import snfce_pkg::*;

  logic [4:0]  density_q;
  logic [15:0] maker_q;
  logic        accept, full, empty, pop, init;
  job_t        push_job, pop_job;

  assign pready = 1'b1;
  assign busy_o = full | init;
  assign accept = start_i & ~busy_o;

  always_comb begin
    prdata = '0;
    if (paddr == REG_DENSITY) prdata = {27'd0, density_q};
    else if (paddr == REG_MAKER) prdata = {16'd0, maker_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      density_q <= DENSITY_RESET;
      maker_q   <= MAKER_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr == REG_DENSITY) density_q <= pwdata[4:0];
      else if (paddr == REG_MAKER) maker_q <= pwdata[15:0];
    end
  end

  snfce_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .cmd_i     (cmd_i),
    .density_i (density_q),
    .maker_i   (maker_q),
    .job_o     (push_job)
  );

  snfce_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_job_i (push_job),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .empty_o    (empty),
    .full_o     (full)
  );

  snfce_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .job_i    (pop_job),
    .pop_o    (pop),
    .init_o   (init),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

@@ src/snfce_front.sv @@
// Front end: tracks the command protocol and turns each transaction into a memory job.
module snfce_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  snfce_pkg::in_t     cmd_i,
  input  logic [4:0]         density_i,
  input  logic [15:0]        maker_i,
  output snfce_pkg::job_t    job_o
);
  import snfce_pkg::*;

  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_ADDR       = 3'd1;
  localparam logic [2:0] PH_RDID       = 3'd2;
  localparam logic [2:0] PH_RDSR       = 3'd3;
  localparam logic [2:0] PH_READ       = 3'd4;
  localparam logic [2:0] PH_PROG_FIRST = 3'd5;
  localparam logic [2:0] PH_PROG_MORE  = 3'd6;
  localparam logic [2:0] PH_DONE       = 3'd7;

  logic [2:0]           phase_q, phase_d;
  logic [7:0]           cmd_q, cmd_d;
  logic [ADDR_BITS-1:0] addr_q, addr_d;
  logic [1:0]           cnt_q, cnt_d;
  logic                 wel_q, wel_d;
  logic                 sel_q, sel_d;
  logic [4:0]           dens;
  logic [ADDR_BITS:0]   size;
  logic [ADDR_BITS-1:0] addr_new;
  logic [ADDR_BITS:0]   erase_end;
  logic                 cur_out, new_out;

  always_comb begin
    dens = density_i;
    if (dens < 5'(MIN_DENSITY)) dens = 5'(MIN_DENSITY);
    if (dens > 5'(MEM_ADDR_BITS)) dens = 5'(MEM_ADDR_BITS);
    size      = (ADDR_BITS+1)'(1) << dens;
    addr_new  = {addr_q[ADDR_BITS-9:0], cmd_i.data_in};
    cur_out   = {1'b0, addr_q} >= size;
    new_out   = {1'b0, addr_new} >= size;
    erase_end = {1'b0, addr_new} + (ADDR_BITS+1)'(SECTOR_BYTES);
    if (erase_end > size) erase_end = size;
  end

  always_comb begin
    phase_d = phase_q;
    cmd_d   = cmd_q;
    addr_d  = addr_q;
    cnt_d   = cnt_q;
    wel_d   = wel_q;
    sel_d   = sel_q;
    job_o   = '0;
    job_o.kind = JOB_RESULT;
    job_o.err  = ERR_OK;
    if (accept_i) begin
      if (cmd_i.op == OP_SELECT || cmd_i.op == OP_DESELECT) begin
        sel_d   = (cmd_i.op == OP_SELECT);
        phase_d = PH_IDLE;
        cnt_d   = '0;
      end else if (!sel_q) begin
        job_o.err = ERR_PHASE;
      end else if (cmd_i.op == OP_WRITE) begin
        unique case (phase_q) inside
          PH_IDLE: begin
            cmd_d   = cmd_i.data_in;
            cnt_d   = '0;
            phase_d = PH_DONE;
            unique case (cmd_i.data_in) inside
              CMD_PDOWN, CMD_RELEASE: ;
              CMD_WREN: wel_d = 1'b1;
              CMD_READ_ID: phase_d = PH_RDID;
              CMD_RDSR: phase_d = PH_RDSR;
              CMD_READ, CMD_PROG, CMD_SECTOR: phase_d = PH_ADDR;
              CMD_BULK: begin
                job_o.kind = JOB_ERASE;
                job_o.last = (MEM_ADDR_BITS+1)'(size);
              end
              default: job_o.err = ERR_CMD;
            endcase
          end
          PH_ADDR: begin
            addr_d = addr_new;
            if (cnt_q < 2'd2) begin
              cnt_d = cnt_q + 2'd1;
            end else begin
              cnt_d = '0;
              if (cmd_q == CMD_READ) begin
                phase_d = PH_READ;
              end else if (cmd_q == CMD_PROG) begin
                phase_d = PH_PROG_FIRST;
              end else begin
                phase_d = PH_DONE;
                if (new_out) begin
                  job_o.err = ERR_RANGE;
                end else if (addr_new[SECTOR_BITS-1:0] != '0) begin
                  job_o.err = ERR_ALIGN;
                end else begin
                  job_o.kind = JOB_ERASE;
                  job_o.addr = addr_new[MEM_ADDR_BITS-1:0];
                  job_o.last = (MEM_ADDR_BITS+1)'(erase_end);
                end
              end
            end
          end
          PH_PROG_FIRST, PH_PROG_MORE: begin
            if (cur_out) begin
              job_o.err = ERR_RANGE;
            end else if (phase_q == PH_PROG_MORE && addr_q[PAGE_BITS-1:0] == '0) begin
              job_o.err = ERR_PAGE;
            end else begin
              job_o.kind = JOB_PROGRAM;
              job_o.addr = addr_q[MEM_ADDR_BITS-1:0];
              job_o.data = cmd_i.data_in;
              addr_d     = addr_q + ADDR_BITS'(1);
              phase_d    = PH_PROG_MORE;
            end
          end
          default: job_o.err = ERR_PHASE;
        endcase
      end else begin
        unique case (phase_q)
          PH_RDID: begin
            case (cnt_q)
              2'd0:    job_o.data = maker_i[15:8];
              2'd1:    job_o.data = maker_i[7:0];
              default: job_o.data = {3'd0, density_i};
            endcase
            if (cnt_q >= 2'd2) begin
              cnt_d   = '0;
              phase_d = PH_IDLE;
            end else begin
              cnt_d = cnt_q + 2'd1;
            end
          end
          PH_RDSR: begin
            job_o.data = {6'd0, wel_q, 1'b0};
            wel_d      = 1'b0;
          end
          PH_READ: begin
            if (cur_out) begin
              job_o.err = ERR_RANGE;
            end else begin
              job_o.kind = JOB_READ;
              job_o.addr = addr_q[MEM_ADDR_BITS-1:0];
              addr_d     = addr_q + ADDR_BITS'(1);
            end
          end
          default: job_o.err = ERR_PHASE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cmd_q   <= '0;
      addr_q  <= '1;
      cnt_q   <= '0;
      wel_q   <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
      wel_q   <= wel_d;
      sel_q   <= sel_d;
    end
  end

endmodule

@@ src/snfce_queue.sv @@
// Short job queue between the front end and the memory back end.
module snfce_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  snfce_pkg::job_t push_job_i,
  input  logic            pop_i,
  output snfce_pkg::job_t pop_job_o,
  output logic            empty_o,
  output logic            full_o
);
  import snfce_pkg::*;

  job_t                 entry_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_q, rd_q;
  logic [QPTR_BITS:0]   count_q;

  assign empty_o   = (count_q == '0);
  assign full_o    = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign pop_job_o = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_q] <= push_job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPTR_BITS'(1);
      if (pop_i) rd_q <= rd_q + QPTR_BITS'(1);
      if (push_i && !pop_i) count_q <= count_q + (QPTR_BITS+1)'(1);
      else if (pop_i && !push_i) count_q <= count_q - (QPTR_BITS+1)'(1);
    end
  end

endmodule

@@ src/snfce_back.sv @@
// Back end: owns the flash array and carries out read, program and erase jobs.
module snfce_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  snfce_pkg::job_t job_i,
  output logic            pop_o,
  output logic            init_o,
  output logic            done_o,
  output snfce_pkg::out_t result_o
);
  import snfce_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_PROG  = 2'd2;
  localparam logic [1:0] ST_SWEEP = 2'd3;

  logic [7:0]               mem [2**MEM_ADDR_BITS];
  logic [1:0]               state_q, state_d;
  logic                     init_q, init_d;
  logic [MEM_ADDR_BITS:0]   swp_q, swp_d, end_q, end_d;
  job_t                     job_q, job_d;
  logic [7:0]               rdata_q;
  logic                     rd_en, we;
  logic [MEM_ADDR_BITS-1:0] waddr;
  logic [7:0]               wdata;
  logic                     done_q, done_d;
  out_t                     res_q, res_d;

  assign init_o   = init_q;
  assign done_o   = done_q;
  assign result_o = res_q;

  always_comb begin
    state_d = state_q;
    init_d  = init_q;
    swp_d   = swp_q;
    end_d   = end_q;
    job_d   = job_q;
    pop_o   = 1'b0;
    rd_en   = 1'b0;
    we      = 1'b0;
    waddr   = swp_q[MEM_ADDR_BITS-1:0];
    wdata   = ERASED_BYTE;
    done_d  = 1'b0;
    res_d   = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          job_d = job_i;
          case (job_i.kind)
            JOB_RESULT: begin
              done_d = 1'b1;
              res_d  = '{data_out: job_i.data, error_code: job_i.err};
            end
            JOB_READ: begin
              rd_en   = 1'b1;
              state_d = ST_READ;
            end
            JOB_PROGRAM: begin
              rd_en   = 1'b1;
              state_d = ST_PROG;
            end
            default: begin
              swp_d   = {1'b0, job_i.addr};
              end_d   = job_i.last;
              state_d = ST_SWEEP;
            end
          endcase
        end
      end
      ST_READ: begin
        done_d  = 1'b1;
        res_d   = '{data_out: rdata_q, error_code: ERR_OK};
        state_d = ST_IDLE;
      end
      ST_PROG: begin
        we      = 1'b1;
        waddr   = job_q.addr;
        wdata   = rdata_q & job_q.data;
        done_d  = 1'b1;
        res_d   = '{data_out: 8'd0, error_code: ERR_OK};
        state_d = ST_IDLE;
      end
      default: begin
        we    = 1'b1;
        wdata = init_q ? swp_q[7:0] + INIT_OFFSET : ERASED_BYTE;
        swp_d = swp_q + (MEM_ADDR_BITS+1)'(1);
        if (swp_d == end_q) begin
          state_d = ST_IDLE;
          init_d  = 1'b0;
          if (!init_q) begin
            done_d = 1'b1;
            res_d  = '{data_out: 8'd0, error_code: ERR_OK};
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[job_i.addr];
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      init_q  <= 1'b1;
      swp_q   <= '0;
      end_q   <= (MEM_ADDR_BITS+1)'(2**MEM_ADDR_BITS);
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      swp_q   <= swp_d;
      end_q   <= end_d;
      done_q  <= done_d;
    end
  end

endmodule
